FILE: rtl/core/sfp_pkg.sv
// sfp_pkg: shared constants, codes and types of the sensor frame parser
// with sum checksum and low-pass temperature filter
// no dependencies
package sfp_pkg;

    // frame field limits
    localparam logic [7:0] MAX_FIELD_VALUE     = 8'd16;
    localparam logic [8:0] FRAME_LIMIT         = 9'd24;
    localparam logic [5:0] HEADER_BYTES        = 6'd5;
    localparam logic [4:0] TEMP_MIN_LENGTH     = 5'd7;

    // byte positions inside a frame
    localparam logic [4:0] POS_ADDRESS   = 5'd0;
    localparam logic [4:0] POS_COMMAND   = 5'd1;
    localparam logic [4:0] POS_START_REG = 5'd2;
    localparam logic [4:0] POS_LENGTH    = 5'd3;
    localparam logic [4:0] POS_TEMP_HIGH = 5'd9;
    localparam logic [4:0] POS_TEMP_LOW  = 5'd10;

    // filter fixed point
    localparam int          FILTER_FRACTION_BITS = 8;
    localparam int          GAIN_SHIFT           = 8;
    localparam logic [23:0] FILTER_MAX           = 24'hFF_FFFF;
    localparam logic [8:0]  GAIN_FULL            = 9'd256;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS       = 2'd0;
    localparam logic [1:0] REG_COMMAND_CODE         = 2'd1;
    localparam logic [1:0] REG_TEMPERATURE_REGISTER = 2'd2;
    localparam logic [1:0] REG_FILTER_GAIN          = 2'd3;

    // configuration reset values
    localparam logic [7:0] DEVICE_ADDRESS_RST       = 8'hA4;
    localparam logic [7:0] COMMAND_CODE_RST         = 8'h03;
    localparam logic [7:0] TEMPERATURE_REGISTER_RST = 8'h07;
    localparam logic [8:0] FILTER_GAIN_RST          = 9'd51;

    // frame status codes
    localparam logic [1:0] STATUS_BAD_SUM = 2'd0;
    localparam logic [1:0] STATUS_GOOD    = 2'd1;
    localparam logic [1:0] STATUS_TEMP    = 2'd2;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] command_code;
        logic [7:0] temperature_register;
        logic [8:0] filter_gain;
    } sfp_cfg_t;

    // what the parser reports for one word
    typedef struct packed {
        logic        done;
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic        sample;
    } sfp_evt_t;

endpackage

FILE: rtl/core/sfp_parser.sv
// sfp_parser: frame state and running checksum, one word per enabled cycle
// depends on sfp_pkg
module sfp_parser
    import sfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] rx_byte,
    input  sfp_cfg_t   cfg,
    output sfp_evt_t   evt
);

    logic [4:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] sreg_seen_reg, sreg_seen_next;
    logic [4:0] len_reg, len_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;

    logic [5:0] last_pos;
    logic [8:0] frame_len;
    logic       advance;

    assign last_pos  = {1'b0, len_reg} + HEADER_BYTES;
    assign frame_len = {1'b0, rx_byte} + 9'(HEADER_BYTES);

    // frame decode for the current word
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        sreg_seen_next = sreg_seen_reg;
        len_next       = len_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        advance        = 1'b0;
        evt.done       = 1'b0;
        evt.status     = STATUS_BAD_SUM;
        evt.temp_raw   = 16'd0;
        evt.sample     = 1'b0;

        unique case (count_reg)
            POS_ADDRESS:
            begin
                if (rx_byte == cfg.device_address)
                begin
                    sum_next   = rx_byte;
                    count_next = POS_COMMAND;
                end
            end
            POS_COMMAND:
            begin
                if (rx_byte != cfg.command_code)
                    count_next = POS_ADDRESS;
                else
                    advance = 1'b1;
            end
            POS_START_REG:
            begin
                if (rx_byte > MAX_FIELD_VALUE)
                    count_next = POS_ADDRESS;
                else
                begin
                    sreg_seen_next = rx_byte;
                    advance        = 1'b1;
                end
            end
            POS_LENGTH:
            begin
                if (rx_byte > MAX_FIELD_VALUE || frame_len > FRAME_LIMIT)
                    count_next = POS_ADDRESS;
                else
                begin
                    len_next = rx_byte[4:0];
                    advance  = 1'b1;
                end
            end
            default:
            begin
                if (({1'b0, count_reg} + 6'd1) >= last_pos)
                begin
                    // checksum word closes the frame
                    count_next = POS_ADDRESS;
                    evt.done   = 1'b1;
                    if (sum_reg != rx_byte)
                        evt.status = STATUS_BAD_SUM;
                    else if (sreg_seen_reg == cfg.temperature_register
                             && len_reg >= TEMP_MIN_LENGTH)
                    begin
                        evt.status   = STATUS_TEMP;
                        evt.temp_raw = {high_reg, low_reg};
                        evt.sample   = 1'b1;
                    end
                    else
                        evt.status = STATUS_GOOD;
                end
                else
                begin
                    if (count_reg == POS_TEMP_HIGH)
                        high_next = rx_byte;
                    else if (count_reg == POS_TEMP_LOW)
                        low_next = rx_byte;
                    advance = 1'b1;
                end
            end
        endcase

        if (advance)
        begin
            sum_next   = sum_reg + rx_byte;
            count_next = count_reg + 5'd1;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            sreg_seen_reg <= '0;
            len_reg       <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
        end
        else if (en)
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sreg_seen_reg <= sreg_seen_next;
            len_reg       <= len_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
        end
    end

endmodule

FILE: rtl/core/sfp_filter.sv
// sfp_filter: first-order low-pass on temperature samples, one multiplier
// depends on sfp_pkg
module sfp_filter
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        sample,
    input  logic [15:0] temp_raw,
    input  logic [8:0]  gain,
    output logic [23:0] value_next
);

    logic        primed_reg;
    logic [23:0] value_reg;

    logic [31:0]        x_wide;
    logic [23:0]        x;
    logic [8:0]         g;
    logic signed [9:0]  g_s;
    logic signed [24:0] d_s;
    logic signed [34:0] prod_s;
    logic signed [34:0] blend_s;
    logic               load;

    // scaled sample, clamped to the filter range
    assign x_wide = 32'(temp_raw) << FILTER_FRACTION_BITS;
    assign x      = (x_wide > 32'(FILTER_MAX)) ? FILTER_MAX : x_wide[23:0];
    assign g      = (gain > GAIN_FULL) ? GAIN_FULL : gain;

    // v + g*(x - v)/256 equals (g*x + (256-g)*v)/256 floored, and stays in range
    assign g_s     = $signed({1'b0, g});
    assign d_s     = $signed({1'b0, x}) - $signed({1'b0, value_reg});
    assign prod_s  = 35'(g_s) * 35'(d_s);
    assign blend_s = $signed({11'd0, value_reg}) + (prod_s >>> GAIN_SHIFT);

    assign load = en && sample;

    always_comb
    begin
        if (!load)
            value_next = value_reg;
        else if (!primed_reg)
            value_next = x;
        else
            value_next = blend_s[23:0];
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            value_reg  <= '0;
        end
        else if (load)
        begin
            primed_reg <= 1'b1;
            value_reg  <= value_next;
        end
    end

endmodule

FILE: rtl/core/sensor_frame_parser_lowpass_top.sv
// sensor_frame_parser_lowpass_top: input word register, parser, filter, result register
// depends on sfp_pkg, sfp_parser, sfp_filter
//
//  channel   direction  payload (low bit first)                        handshake
//  s_*       in         rx_byte[7:0]                                   tvalid/tready
//  m_*       out        frame_status[1:0] temp_raw[17:2]               tvalid/tready
//                       temp_filtered[41:18], zero fill to 48
//  cfg_*     in         index 0..3, data up to 9 bits                  cfg_we only
//
// one received word per cycle sustained unless a checksum word meets a full result slot;
// a result becomes valid once its checksum word has passed the input and result registers
// the critical path is the checksum compare feeding the filter multiplier
// reset clears frame state, filter and handshakes; config returns to defaults
// a stalled result only holds the pipe when another checksum word arrives
module sensor_frame_parser_lowpass_top
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // frame_status[1:0], temp_raw[17:2], temp_filtered[41:18]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata
);

    sfp_cfg_t cfg_reg;

    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;

    sfp_evt_t    evt;
    logic [23:0] filt_next;
    logic        out_free;
    logic        go;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address       <= DEVICE_ADDRESS_RST;
            cfg_reg.command_code         <= COMMAND_CODE_RST;
            cfg_reg.temperature_register <= TEMPERATURE_REGISTER_RST;
            cfg_reg.filter_gain          <= FILTER_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS:       cfg_reg.device_address       <= cfg_wdata[7:0];
                REG_COMMAND_CODE:         cfg_reg.command_code         <= cfg_wdata[7:0];
                REG_TEMPERATURE_REGISTER: cfg_reg.temperature_register <= cfg_wdata[7:0];
                REG_FILTER_GAIN:          cfg_reg.filter_gain          <= cfg_wdata;
            endcase
        end
    end

    // pipe control: a word moves on unless it closes a frame into a full result slot
    assign out_free = !m_valid_reg || m_tready;
    assign go       = stg_valid_reg && (!evt.done || out_free);
    assign s_tready = !stg_valid_reg || go;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            stg_valid_reg <= 1'b1;
        else if (go)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            stg_byte_reg <= s_tdata;
    end

    sfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (go),
        .rx_byte (stg_byte_reg),
        .cfg     (cfg_reg),
        .evt     (evt)
    );

    sfp_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (go),
        .sample     (evt.sample),
        .temp_raw   (evt.temp_raw),
        .gain       (cfg_reg.filter_gain),
        .value_next (filt_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (go && evt.done)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && evt.done)
            m_data_reg <= {6'd0, filt_next, evt.temp_raw, evt.status};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
